@@ design/fmacl_pkg.sv @@
// Package: shared types and constants of the ACL filter.
package fmacl_pkg;

  localparam int unsigned RuleSlots = 16;
  localparam int unsigned NumStats  = 7;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  typedef enum logic [2:0] {
    ModePacket   = 3'd0,
    ModeAdd      = 3'd1,
    ModeDelete   = 3'd2,
    ModeReadStat = 3'd3,
    ModeClear    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    FiltDisabled  = 2'd0,
    FiltBlacklist = 2'd1,
    FiltWhitelist = 2'd2,
    FiltCountOnly = 2'd3
  } filt_e;

  localparam logic [1:0] CfgFilterMode = 2'd0;
  localparam logic [1:0] CfgDropEn     = 2'd1;
  localparam logic [1:0] CfgForwardEn  = 2'd2;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusNotFound = 2'd2;

  localparam logic [1:0] DispDiscard = 2'd0;
  localparam logic [1:0] DispForward = 2'd1;
  localparam logic [1:0] DispDrop    = 2'd2;

  localparam logic [2:0] StatTotal    = 3'd0;
  localparam logic [2:0] StatBytes    = 3'd1;
  localparam logic [2:0] StatTcp      = 3'd2;
  localparam logic [2:0] StatUdp      = 3'd3;
  localparam logic [2:0] StatIcmp     = 3'd4;
  localparam logic [2:0] StatDropped  = 3'd5;
  localparam logic [2:0] StatFiltered = 3'd6;

  // classified request from front to back
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] length;
    logic [2:0]  stat_index;
    logic        filt_on;
    logic        hit;
    logic [31:0] hit_id;
    logic        drop;
    logic        found;
    logic        full;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  disposition;
    logic        hit;
    logic [31:0] hit_rule_id;
    logic [31:0] new_rule_id;
    logic [63:0] stat_value;
  } res_t;

endpackage

@@ design/first_match_packet_acl_filter_unit.sv @@
// Top level: five-tuple first-match ACL filter with statistics.
//  channel | dir | handshake              | payload
//  cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  s_axis  | in  | tvalid/tready          | tdata (request fields)
//  m_axis  | out | tvalid/tready          | tdata (result fields)
// A request is classified in the cycle it is accepted (parallel compare over
// all slots, priority pick) and queued; the back stage then updates counters
// and registers the result: one request per cycle while neither side stalls.
// Reset clears slots, id counter, counters and registers; no clearing pass.
// Either side may stall; the two-entry queue decouples them.
module first_match_packet_acl_filter_unit import fmacl_pkg::*; #(
  parameter int unsigned RULE_SLOTS = RuleSlots
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [1:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode[2:0] is_ipv4[3] ip_protocol[11:4] src_addr[43:12] dst_addr[75:44]
  // sport[91:76] dport[107:92] length[123:108] target_id[155:124]
  // stat_index[158:156], zero to 159
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0] disposition[3:2] hit[4] hit_rule_id[36:5] new_rule_id[68:37]
  // stat_value[132:69], zero to 135
  output logic [135:0] m_axis_tdata
);
  logic [1:0] filter_mode_q;
  logic drop_en_q, forward_en_q;
  logic f_valid, f_ready, b_valid, b_ready;
  req_t f_req, b_req;
  res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q <= FiltDisabled;
      drop_en_q     <= 1'b0;
      forward_en_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgFilterMode: filter_mode_q <= cfg_data_i;
        CfgDropEn:     drop_en_q     <= cfg_data_i[0];
        CfgForwardEn:  forward_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  fmacl_front #(.RULE_SLOTS(RULE_SLOTS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .mode_i(s_axis_tdata[2:0]), .is_ipv4_i(s_axis_tdata[3]),
    .proto_i(s_axis_tdata[11:4]), .src_addr_i(s_axis_tdata[43:12]),
    .dst_addr_i(s_axis_tdata[75:44]), .sport_i(s_axis_tdata[91:76]),
    .dport_i(s_axis_tdata[107:92]), .length_i(s_axis_tdata[123:108]),
    .target_id_i(s_axis_tdata[155:124]), .stat_index_i(s_axis_tdata[158:156]),
    .filter_mode_i(filter_mode_q), .drop_en_i(drop_en_q),
    .q_ready_i(f_ready), .q_valid_o(f_valid), .q_req_o(f_req)
  );

  fmacl_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(f_valid), .in_ready_o(f_ready), .in_req_i(f_req),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_req_o(b_req)
  );

  fmacl_back u_back (
    .clk_i, .rst_ni, .q_valid_i(b_valid), .q_ready_o(b_ready), .q_req_i(b_req),
    .forward_en_i(forward_en_q), .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {3'b000, res.stat_value, res.new_rule_id, res.hit_rule_id,
                         res.hit, res.disposition, res.status};
endmodule

@@ design/fmacl_rule_table.sv @@
// Rule table: slot registers, parallel match, priority pick, add and compacting delete.
module fmacl_rule_table import fmacl_pkg::*; #(
  parameter int unsigned RULE_SLOTS = RuleSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  proto_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] sport_i,
  input  logic [15:0] dport_i,
  input  logic [31:0] target_id_i,
  input  logic        add_i,
  input  logic [31:0] add_id_i,
  input  logic        del_i,
  output logic        hit_o,
  output logic [31:0] hit_id_o,
  output logic        found_o,
  output logic        full_o
);
  localparam int unsigned IdxW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

  logic [RULE_SLOTS-1:0] valid_q;
  logic [7:0]  proto_q [RULE_SLOTS];
  logic [31:0] saddr_q [RULE_SLOTS];
  logic [31:0] daddr_q [RULE_SLOTS];
  logic [15:0] sport_q [RULE_SLOTS];
  logic [15:0] dport_q [RULE_SLOTS];
  logic [31:0] ident_q [RULE_SLOTS];

  logic [RULE_SLOTS-1:0] match, idmatch, del_mask;
  logic [IdxW-1:0] free_idx;
  logic ported;

  assign ported = (proto_i == ProtoTcp) || (proto_i == ProtoUdp);
  assign full_o = valid_q[RULE_SLOTS-1];

  always_comb begin
    for (int i = 0; i < RULE_SLOTS; i++) begin
      match[i] = valid_q[i]
        && (proto_q[i] == '0 || proto_q[i] == proto_i)
        && (saddr_q[i] == '0 || saddr_q[i] == src_addr_i)
        && (daddr_q[i] == '0 || daddr_q[i] == dst_addr_i)
        && (!ported || ((sport_q[i] == '0 || sport_q[i] == sport_i)
                     && (dport_q[i] == '0 || dport_q[i] == dport_i)));
      idmatch[i] = valid_q[i] && (ident_q[i] == target_id_i);
    end
  end

  // first match and first id match; slots are compacted
  always_comb begin
    hit_o    = 1'b0;
    hit_id_o = '0;
    found_o  = 1'b0;
    del_mask = '0;
    free_idx = '0;
    for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_o    = 1'b1;
        hit_id_o = ident_q[i];
      end
      if (!valid_q[i]) free_idx = IdxW'(i);
    end
    for (int i = 0; i < RULE_SLOTS; i++) begin
      if (idmatch[i]) found_o = 1'b1;
      del_mask[i] = found_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (add_i && !full_o) begin
      valid_q[free_idx] <= 1'b1;
    end else if (del_i && found_o) begin
      for (int i = 0; i < RULE_SLOTS; i++)
        if (del_mask[i]) valid_q[i] <= (i + 1 < RULE_SLOTS) ? valid_q[(i+1) % RULE_SLOTS] : 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_i && !full_o) begin
      proto_q[free_idx] <= proto_i;
      saddr_q[free_idx] <= src_addr_i;
      daddr_q[free_idx] <= dst_addr_i;
      sport_q[free_idx] <= sport_i;
      dport_q[free_idx] <= dport_i;
      ident_q[free_idx] <= add_id_i;
    end else if (del_i && found_o) begin
      for (int i = 0; i + 1 < RULE_SLOTS; i++) begin
        if (del_mask[i]) begin
          proto_q[i] <= proto_q[i+1];
          saddr_q[i] <= saddr_q[i+1];
          daddr_q[i] <= daddr_q[i+1];
          sport_q[i] <= sport_q[i+1];
          dport_q[i] <= dport_q[i+1];
          ident_q[i] <= ident_q[i+1];
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (add_i && !full_o) |=> $countones(valid_q) == $past($countones(valid_q)) + 1)
    else $error("add did not fill one slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (del_i && found_o && !add_i) |=> $countones(valid_q) + 1 == $past($countones(valid_q)))
    else $error("delete did not free one slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_q & (valid_q + 1'b1)) == '0))
    else $error("slot table not compacted");
endmodule

@@ design/fmacl_front.sv @@
// Front: accepts requests, classifies against the rule table, updates the table.
module fmacl_front import fmacl_pkg::*; #(
  parameter int unsigned RULE_SLOTS = RuleSlots
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [2:0]   mode_i,
  input  logic         is_ipv4_i,
  input  logic [7:0]   proto_i,
  input  logic [31:0]  src_addr_i,
  input  logic [31:0]  dst_addr_i,
  input  logic [15:0]  sport_i,
  input  logic [15:0]  dport_i,
  input  logic [15:0]  length_i,
  input  logic [31:0]  target_id_i,
  input  logic [2:0]   stat_index_i,
  input  logic [1:0]   filter_mode_i,
  input  logic         drop_en_i,
  input  logic         q_ready_i,
  output logic         q_valid_o,
  output req_t         q_req_o
);
  logic hit, found, full, acc, add, del, filt_on, drop;
  logic [31:0] hit_id, last_id_q, last_id_d;

  assign in_ready_o = q_ready_i;
  assign q_valid_o  = in_valid_i;
  assign acc = in_valid_i && q_ready_i;
  assign add = acc && (mode_i == ModeAdd);
  assign del = acc && (mode_i == ModeDelete);
  assign last_id_d = last_id_q + 32'd1;

  fmacl_rule_table #(.RULE_SLOTS(RULE_SLOTS)) u_table (
    .clk_i, .rst_ni, .proto_i, .src_addr_i, .dst_addr_i, .sport_i, .dport_i,
    .target_id_i, .add_i(add), .add_id_i(last_id_d), .del_i(del),
    .hit_o(hit), .hit_id_o(hit_id), .found_o(found), .full_o(full)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) last_id_q <= '0;
    else if (add && !full) last_id_q <= last_id_d;
  end

  assign filt_on = (filter_mode_i != FiltDisabled) && is_ipv4_i;
  assign drop = drop_en_i && ((filter_mode_i == FiltBlacklist && hit)
                           || (filter_mode_i == FiltWhitelist && !hit));

  always_comb begin
    q_req_o            = '0;
    q_req_o.mode       = mode_i;
    q_req_o.proto      = proto_i;
    q_req_o.src_addr   = src_addr_i;
    q_req_o.dst_addr   = dst_addr_i;
    q_req_o.sport      = sport_i;
    q_req_o.dport      = dport_i;
    q_req_o.length     = length_i;
    q_req_o.stat_index = stat_index_i;
    q_req_o.filt_on    = filt_on;
    q_req_o.hit        = filt_on && hit;
    q_req_o.hit_id     = (filt_on && hit) ? hit_id : '0;
    q_req_o.drop       = filt_on && drop;
    q_req_o.found      = found;
    q_req_o.full       = full;
    if (mode_i == ModeAdd) q_req_o.hit_id = last_id_d;
  end
endmodule

@@ design/fmacl_queue.sv @@
// Queue: short FIFO of classified requests between front and back.
module fmacl_queue import fmacl_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output req_t out_req_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  req_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic push, pop;

  assign in_ready_o  = cnt_q != CntW'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_req_o   = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_req_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(DEPTH))
    else $error("queue overflow");
endmodule

@@ design/fmacl_back.sv @@
// Back: statistic counters and result register.
module fmacl_back import fmacl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  req_t        q_req_i,
  input  logic        forward_en_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o
);
  logic [63:0] cnt_q [NumStats];
  logic res_valid_q, take;
  res_t res_q, res_d;
  logic pkt;

  assign q_ready_o   = !res_valid_q || res_ready_i;
  assign take        = q_valid_i && q_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign pkt = q_req_i.mode == ModePacket;

  always_comb begin
    res_d = '0;
    unique case (q_req_i.mode)
      ModePacket: begin
        if (q_req_i.filt_on) begin
          res_d.hit = q_req_i.hit;
          res_d.hit_rule_id = q_req_i.hit_id;
          res_d.disposition = q_req_i.drop ? DispDrop
                            : (forward_en_i ? DispForward : DispDiscard);
        end
      end
      ModeAdd: begin
        if (q_req_i.full) res_d.status = StatusFull;
        else res_d.new_rule_id = q_req_i.hit_id;
      end
      ModeDelete: if (!q_req_i.found) res_d.status = StatusNotFound;
      ModeReadStat: if (q_req_i.stat_index < 3'(NumStats))
        res_d.stat_value = cnt_q[q_req_i.stat_index];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      for (int i = 0; i < NumStats; i++) cnt_q[i] <= '0;
    end else begin
      if (take) res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
      if (take && q_req_i.mode == ModeClear) begin
        for (int i = 0; i < NumStats; i++) cnt_q[i] <= '0;
      end else if (take && pkt) begin
        cnt_q[StatTotal] <= cnt_q[StatTotal] + 64'd1;
        cnt_q[StatBytes] <= cnt_q[StatBytes] + 64'(q_req_i.length);
        if (q_req_i.filt_on) begin
          if (q_req_i.proto == ProtoTcp) cnt_q[StatTcp] <= cnt_q[StatTcp] + 64'd1;
          else if (q_req_i.proto == ProtoUdp) cnt_q[StatUdp] <= cnt_q[StatUdp] + 64'd1;
          else if (q_req_i.proto == ProtoIcmp) cnt_q[StatIcmp] <= cnt_q[StatIcmp] + 64'd1;
          if (q_req_i.drop) begin
            cnt_q[StatDropped]  <= cnt_q[StatDropped] + 64'd1;
            cnt_q[StatFiltered] <= cnt_q[StatFiltered] + 64'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_ready_i) |=> $stable(res_q))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && q_req_i.mode == ModeClear) |=> cnt_q[StatTotal] == '0)
    else $error("clear missed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[StatDropped] == cnt_q[StatFiltered])
    else $error("dropped and filtered counters differ");
endmodule

@@ test/tb_top.sv @@
// Testbench: ACL filter checked against a behavioural predictor, with random idling.
`timescale 1ns / 100ps

module tb_top;
  import fmacl_pkg::*;

  typedef struct packed {
    logic [2:0]  mode;
    logic        is_ipv4;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] length;
    logic [31:0] target_id;
    logic [2:0]  stat_index;
  } acl_req_t;

  localparam int unsigned CycleLimit = 600000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [1:0]   cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;

  // filter settings and rule table as the block should hold them
  logic [1:0]  cur_filt;
  logic        cur_drop_en, cur_fwd_en;
  logic        tbl_valid [RuleSlots];
  logic [7:0]  tbl_proto [RuleSlots];
  logic [31:0] tbl_saddr [RuleSlots];
  logic [31:0] tbl_daddr [RuleSlots];
  logic [15:0] tbl_sport [RuleSlots];
  logic [15:0] tbl_dport [RuleSlots];
  logic [31:0] tbl_ident [RuleSlots];
  logic [31:0] last_id;
  logic [63:0] stat_cnt [NumStats];

  res_t        expected_results[$];
  int unsigned n_errors = 0;
  int unsigned cycles = 0;
  bit          idling_on = 1'b1;
  int unsigned ready_stall = 0;

  logic [31:0] addr_pool [4] = '{32'h0a00_0001, 32'hc0a8_0102, 32'hffff_ffff, 32'h0};
  logic [15:0] port_pool [4] = '{16'd80, 16'd443, 16'hffff, 16'd0};

  first_match_packet_acl_filter_unit u_top (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic res_t classify(acl_req_t rq);
    res_t r;
    bit   ported, drop;
    int   idx;
    r = '0;
    idx = -1;
    case (rq.mode)
      ModePacket: begin
        stat_cnt[StatTotal] += 64'd1;
        stat_cnt[StatBytes] += 64'(rq.length);
        if (cur_filt != FiltDisabled && rq.is_ipv4) begin
          ported = (rq.proto == ProtoTcp || rq.proto == ProtoUdp);
          for (int i = 0; i < RuleSlots; i++) begin
            if (!tbl_valid[i]) break;
            if (tbl_proto[i] != 0 && tbl_proto[i] != rq.proto) continue;
            if (tbl_saddr[i] != 0 && tbl_saddr[i] != rq.src_addr) continue;
            if (tbl_daddr[i] != 0 && tbl_daddr[i] != rq.dst_addr) continue;
            if (ported && tbl_sport[i] != 0 && tbl_sport[i] != rq.sport) continue;
            if (ported && tbl_dport[i] != 0 && tbl_dport[i] != rq.dport) continue;
            r.hit = 1'b1;
            r.hit_rule_id = tbl_ident[i];
            break;
          end
          drop = cur_drop_en && ((cur_filt == FiltBlacklist && r.hit) ||
                                 (cur_filt == FiltWhitelist && !r.hit));
          if (rq.proto == ProtoTcp) stat_cnt[StatTcp] += 64'd1;
          else if (rq.proto == ProtoUdp) stat_cnt[StatUdp] += 64'd1;
          else if (rq.proto == ProtoIcmp) stat_cnt[StatIcmp] += 64'd1;
          if (drop) begin
            stat_cnt[StatDropped] += 64'd1;
            stat_cnt[StatFiltered] += 64'd1;
            r.disposition = DispDrop;
          end else begin
            r.disposition = cur_fwd_en ? DispForward : DispDiscard;
          end
        end
      end
      ModeAdd: begin
        for (int i = 0; i < RuleSlots; i++)
          if (!tbl_valid[i]) begin idx = i; break; end
        if (idx < 0) begin
          r.status = StatusFull;
        end else begin
          last_id = last_id + 32'd1;
          tbl_valid[idx] = 1'b1;
          tbl_proto[idx] = rq.proto;
          tbl_saddr[idx] = rq.src_addr;
          tbl_daddr[idx] = rq.dst_addr;
          tbl_sport[idx] = rq.sport;
          tbl_dport[idx] = rq.dport;
          tbl_ident[idx] = last_id;
          r.new_rule_id = last_id;
        end
      end
      ModeDelete: begin
        for (int i = 0; i < RuleSlots; i++)
          if (tbl_valid[i] && tbl_ident[i] == rq.target_id) begin idx = i; break; end
        if (idx < 0) begin
          r.status = StatusNotFound;
        end else begin
          for (int i = idx; i + 1 < RuleSlots; i++) begin
            tbl_valid[i] = tbl_valid[i+1];
            tbl_proto[i] = tbl_proto[i+1];
            tbl_saddr[i] = tbl_saddr[i+1];
            tbl_daddr[i] = tbl_daddr[i+1];
            tbl_sport[i] = tbl_sport[i+1];
            tbl_dport[i] = tbl_dport[i+1];
            tbl_ident[i] = tbl_ident[i+1];
          end
          tbl_valid[RuleSlots-1] = 1'b0;
        end
      end
      ModeReadStat: if (rq.stat_index < NumStats) r.stat_value = stat_cnt[rq.stat_index];
      ModeClear: for (int i = 0; i < NumStats; i++) stat_cnt[i] = '0;
      default: ;
    endcase
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    res_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status      = m_axis_tdata[1:0];
      got.disposition = m_axis_tdata[3:2];
      got.hit         = m_axis_tdata[4];
      got.hit_rule_id = m_axis_tdata[36:5];
      got.new_rule_id = m_axis_tdata[68:37];
      got.stat_value  = m_axis_tdata[132:69];
      if (expected_results.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        n_errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.status != exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, got.status); n_errors++;
        end
        if (got.disposition != exp_r.disposition) begin
          $error("disposition exp %0d got %0d", exp_r.disposition, got.disposition);
          n_errors++;
        end
        if (got.hit != exp_r.hit) begin
          $error("hit exp %0d got %0d", exp_r.hit, got.hit); n_errors++;
        end
        if (got.hit_rule_id != exp_r.hit_rule_id) begin
          $error("hit_rule_id exp %0d got %0d", exp_r.hit_rule_id, got.hit_rule_id);
          n_errors++;
        end
        if (got.new_rule_id != exp_r.new_rule_id) begin
          $error("new_rule_id exp %0d got %0d", exp_r.new_rule_id, got.new_rule_id);
          n_errors++;
        end
        if (got.stat_value != exp_r.stat_value) begin
          $error("stat_value exp %0d got %0d", exp_r.stat_value, got.stat_value);
          n_errors++;
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (ready_stall > 0) begin
      ready_stall--;
      m_axis_tready = 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      ready_stall = $urandom_range(0, 8);
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  task automatic send_request(acl_req_t rq);
    if (idling_on && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {1'b0, rq.stat_index, rq.target_id, rq.length, rq.dport,
                    rq.sport, rq.dst_addr, rq.src_addr, rq.proto, rq.is_ipv4, rq.mode};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(classify(rq));
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgFilterMode: cur_filt = val;
      CfgDropEn:     cur_drop_en = val[0];
      CfgForwardEn:  cur_fwd_en = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_filter(logic [1:0] fm, logic de, logic fe);
    drain();
    cfg_write(CfgFilterMode, fm);
    cfg_write(CfgDropEn, {1'b0, de});
    cfg_write(CfgForwardEn, {1'b0, fe});
  endtask

  function automatic acl_req_t mk(logic [2:0] md, logic [7:0] pr, logic [31:0] sa,
                                  logic [31:0] da, logic [15:0] sp, logic [15:0] dp);
    acl_req_t rq;
    rq = '0;
    rq.mode = md; rq.is_ipv4 = 1'b1; rq.proto = pr;
    rq.src_addr = sa; rq.dst_addr = da; rq.sport = sp; rq.dport = dp;
    rq.length = 16'd64;
    return rq;
  endfunction

  task automatic test_directed();
    acl_req_t rq;
    set_filter(FiltBlacklist, 1'b1, 1'b1);
    send_request(mk(ModePacket, ProtoTcp, 32'h1, 32'h2, 16'd1, 16'd80));
    send_request(mk(ModeAdd, ProtoTcp, addr_pool[0], 32'h0, 16'h0, 16'd80));
    send_request(mk(ModeAdd, ProtoUdp, 32'h0, addr_pool[1], 16'hffff, 16'h0));
    send_request(mk(ModeAdd, ProtoIcmp, addr_pool[2], 32'h0, 16'd5, 16'd5));
    send_request(mk(ModePacket, ProtoTcp, addr_pool[0], 32'h9, 16'd7, 16'd80));
    send_request(mk(ModePacket, ProtoTcp, addr_pool[0], 32'h9, 16'd7, 16'd81));
    send_request(mk(ModePacket, ProtoUdp, 32'h5, addr_pool[1], 16'hffff, 16'd0));
    // ICMP rule ports are not checked
    send_request(mk(ModePacket, ProtoIcmp, addr_pool[2], 32'h0, 16'd0, 16'd0));
    rq = mk(ModePacket, ProtoTcp, addr_pool[0], 32'hffff_ffff, 16'hffff, 16'd80);
    rq.is_ipv4 = 1'b0; rq.length = 16'hffff;
    send_request(rq);
    send_request(mk(ModeDelete, 8'h0, 32'h0, 32'h0, 16'h0, 16'h0));
    rq = mk(ModeDelete, 8'h0, 32'h0, 32'h0, 16'h0, 16'h0);
    rq.target_id = 32'd2;
    send_request(rq);
    rq.target_id = 32'hffff_ffff;
    send_request(rq);
    send_request(mk(ModePacket, ProtoIcmp, addr_pool[2], 32'h0, 16'd0, 16'd0));
    for (int i = 0; i < 8; i++) begin
      rq = mk(ModeReadStat, 8'h0, 32'h0, 32'h0, 16'h0, 16'h0);
      rq.stat_index = 3'(i);
      send_request(rq);
    end
    send_request(mk(ModeClear, 8'h0, 32'h0, 32'h0, 16'h0, 16'h0));
    send_request(mk(3'd7, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff));
    send_request(mk(ModeReadStat, 8'h0, 32'h0, 32'h0, 16'h0, 16'h0));
  endtask

  task automatic test_table_full();
    for (int i = 0; i <= RuleSlots; i++)
      send_request(mk(ModeAdd, 8'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom)));
    send_request(mk(ModePacket, ProtoUdp, $urandom, $urandom, 16'($urandom), 16'($urandom)));
  endtask

  function automatic acl_req_t random_request();
    acl_req_t rq;
    int unsigned pick, nvalid;
    pick = $urandom_range(0, 99);
    rq = mk(ModePacket, 8'h0, 32'h0, 32'h0, 16'h0, 16'h0);
    rq.proto = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
               ($urandom_range(0, 3) == 0 ? 8'h0 : ProtoTcp);
    case ($urandom_range(0, 3))
      0: rq.proto = ProtoUdp;
      1: rq.proto = ProtoIcmp;
      default: ;
    endcase
    rq.src_addr = addr_pool[$urandom_range(0, 3)];
    rq.dst_addr = addr_pool[$urandom_range(0, 3)];
    rq.sport = port_pool[$urandom_range(0, 3)];
    rq.dport = port_pool[$urandom_range(0, 3)];
    rq.length = 16'($urandom);
    rq.stat_index = 3'($urandom_range(0, 7));
    if (pick < 8) begin
      // noise: every field random
      rq = acl_req_t'(159'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      if (rq.mode != ModeDelete && rq.mode != ModeAdd && rq.mode != ModePacket)
        rq.mode = 3'($urandom_range(3, 7));
      return rq;
    end
    nvalid = 0;
    for (int i = 0; i < RuleSlots; i++) if (tbl_valid[i]) nvalid++;
    if (pick < 55) begin
      rq.mode = ModePacket;
      rq.is_ipv4 = ($urandom_range(0, 9) != 0);
      if (rq.src_addr == 0) rq.src_addr = $urandom;
    end else if (pick < 72) begin
      rq.mode = ModeAdd;
    end else if (pick < 86) begin
      rq.mode = ModeDelete;
      rq.target_id = (nvalid > 0 && $urandom_range(0, 4) != 0) ?
                     tbl_ident[$urandom_range(0, nvalid - 1)] : $urandom;
    end else if (pick < 97) begin
      rq.mode = ModeReadStat;
    end else begin
      rq.mode = ModeClear;
    end
    return rq;
  endfunction

  task automatic test_random(logic [1:0] fm, logic de, logic fe, int unsigned n);
    set_filter(fm, de, fe);
    repeat (n) send_request(random_request());
  endtask

  initial begin
    cur_filt = FiltDisabled;
    cur_drop_en = 1'b0;
    cur_fwd_en = 1'b0;
    last_id = '0;
    for (int i = 0; i < RuleSlots; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < NumStats; i++) stat_cnt[i] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_table_full();
    test_random(FiltDisabled, 1'b0, 1'b0, 250);
    test_random(FiltBlacklist, 1'b1, 1'b1, 350);
    test_random(FiltWhitelist, 1'b1, 1'b0, 350);
    test_random(FiltCountOnly, 1'b1, 1'b1, 300);
    test_random(FiltBlacklist, 1'b0, 1'b1, 250);
    test_random(FiltWhitelist, 1'b0, 1'b1, 250);
    idling_on = 1'b0;
    test_random(FiltWhitelist, 1'b1, 1'b1, 250);
    s_axis_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
